// ===== hw/rtl/aabbct_pkg.sv =====
package aabbct_pkg;

    localparam int ID_W        = 5;
    localparam int COORD_W     = 16;
    localparam int ID_MAX_BITS = 8;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } contact_event_t;

    typedef enum logic {
        ACT_TEST  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

// ===== hw/rtl/aabbct_axis_overlap.sv =====
module aabbct_axis_overlap (
    input  logic signed [aabbct_pkg::COORD_W-1:0] ca,
    input  logic        [aabbct_pkg::COORD_W-1:0] sa,
    input  logic signed [aabbct_pkg::COORD_W-1:0] cb,
    input  logic        [aabbct_pkg::COORD_W-1:0] sb,
    output logic                                  ov
);

    localparam int W = aabbct_pkg::COORD_W;

    logic signed [W:0] diff;
    logic        [W:0] mag;
    logic        [W:0] twice;
    logic        [W:0] sum;

    // |dx| never exceeds 2^W-1, so doubling it fits in W+1 bits
    always_comb
    begin
        diff  = {ca[W-1], ca} - {cb[W-1], cb};
        mag   = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
        twice = {mag[W-1:0], 1'b0};
        sum   = {1'b0, sa} + {1'b0, sb};
        ov    = twice < sum;
    end

endmodule

// ===== hw/rtl/aabbct_contact_mem.sv =====
module aabbct_contact_mem #(
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/aabb_contact_event_tracker_core.sv =====
// AABB contact event tracker.
// Input channel (in_valid / in_stall) carries one test or clear item per transfer;
// output channel (out_valid / out_stall) returns exactly one result per item, in order.
// A test reads the contact bit of pair (left_id, right_id) from a one-port-read,
// one-port-write memory, reports enter / stay / exit / none and writes the new bit.
// Each item is registered in the lookup stage, and its result in the output register
// that drives out_valid and holds it while out_stall is high.
// Throughput: one test per cycle while the output does not stall and no clearing walk runs;
// same-pair tests in consecutive cycles are handled by forwarding the bit being written.
// A clear item returns its result when it leaves the lookup stage, then the block
// walks the contact memory one entry per cycle over all 2^(2*ID_BITS) entries (1024 at
// the default), holding in_stall high.
// After reset the same clearing walk runs before the first item is taken.
// When the receiver stalls, the output register holds its result; an item in the lookup
// stage is held there and in_stall rises until the output drains.
module aabb_contact_event_tracker_core #(
    parameter int ID_BITS = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic        [aabbct_pkg::ID_W-1:0]    left_id,
    input  logic        [aabbct_pkg::ID_W-1:0]    right_id,
    input  logic signed [aabbct_pkg::COORD_W-1:0] left_x,
    input  logic signed [aabbct_pkg::COORD_W-1:0] left_y,
    input  logic        [aabbct_pkg::COORD_W-1:0] left_w,
    input  logic        [aabbct_pkg::COORD_W-1:0] left_h,
    input  logic signed [aabbct_pkg::COORD_W-1:0] right_x,
    input  logic signed [aabbct_pkg::COORD_W-1:0] right_y,
    input  logic        [aabbct_pkg::COORD_W-1:0] right_w,
    input  logic        [aabbct_pkg::COORD_W-1:0] right_h,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [1:0]                     contact_event,
    output logic                                  overlapping
);

    localparam int PAIR_BITS = 2 * ID_BITS;

    aabbct_pkg::state_t state_reg, state_next;

    logic [PAIR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 clr_last;
    logic                 clr_start;
    logic                 base_stall;

    logic [aabbct_pkg::ID_MAX_BITS-1:0] lid_ext, rid_ext;
    logic [PAIR_BITS-1:0]               in_idx;
    logic                               ov_x, ov_y, in_hit;
    logic                               accept;

    logic                 a_valid_reg, a_valid_next;
    logic                 a_clear_reg;
    logic                 a_hit_reg;
    logic [PAIR_BITS-1:0] a_idx_reg;
    logic                 a_fwd_reg;
    logic                 a_fwd_bit_reg;
    logic                 a_adv;
    logic                 cur_bit;

    logic                 mem_we;
    logic [PAIR_BITS-1:0] mem_waddr;
    logic                 mem_wdata;
    logic                 mem_rdata;

    logic                       out_valid_reg, out_valid_next;
    aabbct_pkg::contact_event_t out_event_reg, ev_calc;
    logic                       out_ov_reg;

    // ---------------- clearing sequencer ----------------
    assign clr_last  = &clr_cnt_reg;
    assign clr_start = a_adv && a_clear_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aabbct_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = aabbct_pkg::ST_RUN;
                end
            end
            aabbct_pkg::ST_RUN:
            begin
                if (clr_start)
                begin
                    state_next = aabbct_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = aabbct_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        base_stall   = 1'b1;
        clr_cnt_next = '0;
        case (state_reg)
            aabbct_pkg::ST_CLEAR:
            begin
                base_stall   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            aabbct_pkg::ST_RUN:
            begin
                base_stall   = 1'b0;
                clr_cnt_next = '0;
            end
            default:
            begin
                base_stall   = 1'b1;
                clr_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= aabbct_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ---------------- input side ----------------
    aabbct_axis_overlap u_ov_x (
        .ca (left_x),
        .sa (left_w),
        .cb (right_x),
        .sb (right_w),
        .ov (ov_x)
    );

    aabbct_axis_overlap u_ov_y (
        .ca (left_y),
        .sa (left_h),
        .cb (right_y),
        .sb (right_h),
        .ov (ov_y)
    );

    assign in_hit  = ov_x && ov_y;
    assign lid_ext = aabbct_pkg::ID_MAX_BITS'(left_id);
    assign rid_ext = aabbct_pkg::ID_MAX_BITS'(right_id);
    assign in_idx  = {lid_ext[ID_BITS-1:0], rid_ext[ID_BITS-1:0]};

    assign a_adv    = a_valid_reg && (!out_valid_reg || !out_stall);
    // a clear in the lookup stage blocks new reads until its walk is done
    assign in_stall = base_stall || (a_valid_reg && (a_clear_reg || !a_adv));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_clear_reg   <= (action == aabbct_pkg::ACT_CLEAR);
            a_hit_reg     <= in_hit;
            a_idx_reg     <= in_idx;
            // the stage ahead writes this pair in the same cycle as our read
            a_fwd_reg     <= a_adv && (a_idx_reg == in_idx);
            a_fwd_bit_reg <= a_hit_reg;
        end
    end

    // ---------------- contact memory ----------------
    always_comb
    begin
        if (state_reg == aabbct_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = a_adv && !a_clear_reg;
            mem_waddr = a_idx_reg;
            mem_wdata = a_hit_reg;
        end
    end

    aabbct_contact_mem #(
        .ADDR_W (PAIR_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (mem_rdata)
    );

    // ---------------- event and output register ----------------
    assign cur_bit = a_fwd_reg ? a_fwd_bit_reg : mem_rdata;

    always_comb
    begin
        if (a_clear_reg)
        begin
            ev_calc = aabbct_pkg::EV_NONE;
        end
        else if (a_hit_reg)
        begin
            ev_calc = cur_bit ? aabbct_pkg::EV_STAY : aabbct_pkg::EV_ENTER;
        end
        else
        begin
            ev_calc = cur_bit ? aabbct_pkg::EV_EXIT : aabbct_pkg::EV_NONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (a_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            out_event_reg <= ev_calc;
            out_ov_reg    <= a_hit_reg && !a_clear_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign contact_event = out_event_reg;
    assign overlapping   = out_ov_reg;

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aabbct_pkg::ST_CLEAR) |-> !accept)
        else $error("item accepted during clearing walk");

    a_exit_not_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == aabbct_pkg::EV_EXIT) |-> !out_ov_reg)
        else $error("exit reported while boxes overlap");

    a_enter_stay_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_event_reg == aabbct_pkg::EV_ENTER ||
                           out_event_reg == aabbct_pkg::EV_STAY)) |-> out_ov_reg)
        else $error("enter or stay reported without overlap");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_idx_reg)))
        else $error("lookup stage lost its item while blocked");

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W    = aabbct_pkg::ID_W;
    localparam int COORD_W = aabbct_pkg::COORD_W;

    typedef struct {
        aabbct_pkg::action_t       act;
        logic        [ID_W-1:0]    lid;
        logic        [ID_W-1:0]    rid;
        logic signed [COORD_W-1:0] lx;
        logic signed [COORD_W-1:0] ly;
        logic        [COORD_W-1:0] lw;
        logic        [COORD_W-1:0] lh;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic        [COORD_W-1:0] rw;
        logic        [COORD_W-1:0] rh;
    } pair_item_t;

    typedef struct {
        aabbct_pkg::contact_event_t ev;
        logic                       hit;
    } contact_result_t;

    class contact_scoreboard;
        bit              contact_bits [1 << (2 * ID_W)];
        contact_result_t pending_results [$];
        int              errors;

        function new();
            errors = 0;
            foreach (contact_bits[i]) contact_bits[i] = 1'b0;
        endfunction

        // exact integer test: 2*|ca-cb| < size_a+size_b
        function bit axis_hit(logic signed [COORD_W-1:0] ca, logic [COORD_W-1:0] size_a,
                              logic signed [COORD_W-1:0] cb, logic [COORD_W-1:0] size_b);
            int d;
            d = int'(ca) - int'(cb);
            if (d < 0) d = -d;
            return (2 * d) < (int'(size_a) + int'(size_b));
        endfunction

        function void note_item(pair_item_t it);
            contact_result_t r;
            logic [2*ID_W-1:0] idx;
            if (it.act == aabbct_pkg::ACT_CLEAR)
            begin
                foreach (contact_bits[i]) contact_bits[i] = 1'b0;
                r.ev  = aabbct_pkg::EV_NONE;
                r.hit = 1'b0;
            end
            else
            begin
                idx   = {it.lid, it.rid};
                r.hit = axis_hit(it.lx, it.lw, it.rx, it.rw) &&
                        axis_hit(it.ly, it.lh, it.ry, it.rh);
                if (r.hit)
                begin
                    r.ev = contact_bits[idx] ? aabbct_pkg::EV_STAY : aabbct_pkg::EV_ENTER;
                    contact_bits[idx] = 1'b1;
                end
                else
                begin
                    r.ev = contact_bits[idx] ? aabbct_pkg::EV_EXIT : aabbct_pkg::EV_NONE;
                    contact_bits[idx] = 1'b0;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] ev, logic hit);
            contact_result_t r;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: contact_event %0d overlapping %0d", ev, hit);
                errors++;
            end
            else
            begin
                r = pending_results.pop_front();
                if (ev !== r.ev)
                begin
                    $error("contact_event: expected %0d, got %0d", r.ev, ev);
                    errors++;
                end
                if (hit !== r.hit)
                begin
                    $error("overlapping: expected %0d, got %0d", r.hit, hit);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      action = aabbct_pkg::ACT_TEST;
    logic        [ID_W-1:0]    left_id = '0;
    logic        [ID_W-1:0]    right_id = '0;
    logic signed [COORD_W-1:0] left_x = '0;
    logic signed [COORD_W-1:0] left_y = '0;
    logic        [COORD_W-1:0] left_w = '0;
    logic        [COORD_W-1:0] left_h = '0;
    logic signed [COORD_W-1:0] right_x = '0;
    logic signed [COORD_W-1:0] right_y = '0;
    logic        [COORD_W-1:0] right_w = '0;
    logic        [COORD_W-1:0] right_h = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic        [1:0]         contact_event;
    logic                      overlapping;

    int gap_pct = 0;
    int stall_pct = 0;

    contact_scoreboard sb = new();

    aabb_contact_event_tracker_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .left_id       (left_id),
        .right_id      (right_id),
        .left_x        (left_x),
        .left_y        (left_y),
        .left_w        (left_w),
        .left_h        (left_h),
        .right_x       (right_x),
        .right_y       (right_y),
        .right_w       (right_w),
        .right_h       (right_h),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .contact_event (contact_event),
        .overlapping   (overlapping)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(contact_event, overlapping);
    end

    task automatic send(input pair_item_t it);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action   <= it.act;
        left_id  <= it.lid;
        right_id <= it.rid;
        left_x   <= it.lx;
        left_y   <= it.ly;
        left_w   <= it.lw;
        left_h   <= it.lh;
        right_x  <= it.rx;
        right_y  <= it.ry;
        right_w  <= it.rw;
        right_h  <= it.rh;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
    endtask

    task automatic test_pair(input int lid, input int rid,
                             input int lx, input int ly, input int lw, input int lh,
                             input int rx, input int ry, input int rw, input int rh);
        pair_item_t it;
        it.act = aabbct_pkg::ACT_TEST;
        it.lid = ID_W'(lid);
        it.rid = ID_W'(rid);
        it.lx  = COORD_W'(lx);
        it.ly  = COORD_W'(ly);
        it.lw  = COORD_W'(lw);
        it.lh  = COORD_W'(lh);
        it.rx  = COORD_W'(rx);
        it.ry  = COORD_W'(ry);
        it.rw  = COORD_W'(rw);
        it.rh  = COORD_W'(rh);
        send(it);
    endtask

    function automatic pair_item_t random_item();
        pair_item_t it;
        int mode;
        mode   = $urandom_range(0, 99);
        it.act = aabbct_pkg::ACT_TEST;
        it.lid = ID_W'($urandom);
        it.rid = ID_W'($urandom);
        it.lx  = COORD_W'($urandom);
        it.ly  = COORD_W'($urandom);
        it.lw  = COORD_W'($urandom);
        it.lh  = COORD_W'($urandom);
        it.rx  = COORD_W'($urandom);
        it.ry  = COORD_W'($urandom);
        it.rw  = COORD_W'($urandom);
        it.rh  = COORD_W'($urandom);
        if (mode < 1)
        begin
            it.act = aabbct_pkg::ACT_CLEAR;
        end
        else if (mode < 80)
        begin
            // few pairs, nearby boxes: drives enter/stay/exit sequences
            it.lid = ID_W'($urandom_range(0, 3));
            it.rid = ID_W'($urandom_range(0, 3));
            it.rx  = it.lx + COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
            it.ry  = it.ly + COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
            it.lw  = COORD_W'($urandom_range(0, 320));
            it.lh  = COORD_W'($urandom_range(0, 320));
            it.rw  = COORD_W'($urandom_range(0, 320));
            it.rh  = COORD_W'($urandom_range(0, 320));
        end
        return it;
    endfunction

    task automatic run_phase(input int n, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n) send(random_item());
    endtask

    initial
    begin
        pair_item_t clr;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pair(0, 0, 0, 0, 16, 16, 8, 8, 16, 16);
        test_pair(0, 0, 0, 0, 16, 16, 8, 8, 16, 16);
        test_pair(0, 0, 0, 0, 16, 16, 16, 0, 16, 16);    // edges touch: exit
        test_pair(0, 0, 0, 0, 16, 16, 16, 0, 16, 16);
        test_pair(1, 2, 0, 0, 32, 32, 0, 0, 32, 32);
        test_pair(2, 1, 0, 0, 32, 32, 0, 0, 32, 32);      // reversed pair has its own bit
        test_pair(1, 2, 0, 0, 32, 32, 0, 0, 32, 32);
        test_pair(3, 3, 100, 100, 0, 0, 100, 100, 0, 0);  // zero-size boxes
        test_pair(3, 3, 100, 100, 1, 0, 100, 100, 0, 1);
        test_pair(31, 31, -32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535);
        test_pair(31, 0, -32768, 32767, 65535, 65535, 32766, -32767, 65535, 65535);
        test_pair(31, 0, 32767, 32767, 1, 1, 32767, 32767, 1, 1);
        test_pair(0, 31, 0, 0, 65535, 0, 0, 0, 0, 65535);
        test_pair(5, 6, 0, 0, 8, 8, 5, 0, 1, 2);
        test_pair(5, 6, 0, 0, 100, 8, 0, 5, 100, 1);
        clr     = random_item();
        clr.act = aabbct_pkg::ACT_CLEAR;
        send(clr);
        test_pair(0, 0, 0, 0, 16, 16, 8, 8, 16, 16);
        test_pair(1, 2, 0, 0, 32, 32, 0, 0, 32, 32);
        test_pair(31, 0, -32768, 0, 4, 4, 32767, 0, 4, 4);

        run_phase(400, 0, 0);
        run_phase(400, 48, 0);
        // hold off until the pipeline is empty
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        run_phase(400, 0, 48);
        run_phase(400, 25, 25);
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/aabbct_pkg.sv
hw/rtl/aabbct_axis_overlap.sv
hw/rtl/aabbct_contact_mem.sv
hw/rtl/aabb_contact_event_tracker_core.sv
verif/tb.sv
